/* hdl/gda_pkg.sv */
// Package with the shared types, constants and calendar function of the date adder.
package gda_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ADD_W   = 16;
  localparam int ORD_W   = 17;
  localparam int LEN_W   = 9;
  localparam int CENT_W  = 7;
  localparam int QUO_W   = 8;

  localparam logic [YEAR_W-1:0]  YEAR_LIMIT  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
  localparam logic [CENT_W-1:0]  CENT_TOP    = 7'd99;
  localparam logic [12:0]        RECIP_100   = 13'd5243;
  localparam int                 RECIP_SHIFT = 19;
  localparam logic [6:0]         HUNDRED     = 7'd100;
  localparam logic [LEN_W-1:0]   YEAR_DAYS   = 9'd365;
  localparam logic [LEN_W-1:0]   LEAP_DAYS   = 9'd366;
  localparam logic [DAY_W-1:0]   FEB_LEAP    = 5'd29;

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [ADD_W-1:0]   days_to_add;
  } req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               error;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_CHECK,
    ST_SUM,
    ST_YEAR,
    ST_MONTH
  } state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1:    n = 5'd31;
      4'd2:    n = 5'd28;
      4'd3:    n = 5'd31;
      4'd4:    n = 5'd30;
      4'd5:    n = 5'd31;
      4'd6:    n = 5'd30;
      4'd7:    n = 5'd31;
      4'd8:    n = 5'd31;
      4'd9:    n = 5'd30;
      4'd10:   n = 5'd31;
      4'd11:   n = 5'd30;
      4'd12:   n = 5'd31;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

/* hdl/gda_calendar.sv */
// Leap year rule and month and year lengths from the year split into century and year of century.
module gda_calendar (
  input  logic [gda_pkg::CENT_W-1:0]  yr_lo,
  input  logic [gda_pkg::CENT_W-1:0]  yr_hi,
  input  logic [gda_pkg::MONTH_W-1:0] month,
  output logic [gda_pkg::DAY_W-1:0]   month_days,
  output logic [gda_pkg::LEN_W-1:0]   year_days
);

  logic leap;

  always_comb begin
    if (yr_lo != '0) begin
      leap = (yr_lo[1:0] == 2'b00);
    end else begin
      leap = (yr_hi[1:0] == 2'b00);
    end
    if (month == gda_pkg::MONTH_FEB && leap) begin
      month_days = gda_pkg::FEB_LEAP;
    end else begin
      month_days = gda_pkg::month_len(month);
    end
    year_days = leap ? gda_pkg::LEAP_DAYS : gda_pkg::YEAR_DAYS;
  end

endmodule

/* hdl/gregorian_date_add_days.sv */
// Top level of the Gregorian date adder: sequencer around one shared adder and comparator.
// After the division and remainder steps, an invalid date ends at the check; otherwise the
// sequencer sums the months before the start month, walks the years and then the months.
// The year walk runs one year per cycle through the shared adder.
// One date is in work at a time; busy is high until the result is shown.
// Done is high for a single cycle and the result holds until the next; the receiver cannot stall.
// Synchronous reset returns the sequencer to idle and clears done.
module gregorian_date_add_days (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  gda_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output gda_pkg::rsp_t result
);

  gda_pkg::state_t state, state_next;

  logic [gda_pkg::YEAR_W-1:0]  year, year_next;
  logic [gda_pkg::MONTH_W-1:0] mon, mon_next;
  logic [gda_pkg::DAY_W-1:0]   day, day_next;
  logic [gda_pkg::ADD_W-1:0]   add, add_next;
  logic [gda_pkg::QUO_W-1:0]   quo, quo_next;
  logic [gda_pkg::CENT_W-1:0]  yr_lo, yr_lo_next;
  logic [gda_pkg::CENT_W-1:0]  yr_hi, yr_hi_next;
  logic [gda_pkg::ORD_W-1:0]   ord, ord_next;
  logic [gda_pkg::MONTH_W-1:0] cnt, cnt_next;
  gda_pkg::rsp_t               res, res_next;
  logic                        done_r, done_next;

  logic [gda_pkg::MONTH_W-1:0] cal_month;
  logic [gda_pkg::DAY_W-1:0]   month_days;
  logic [gda_pkg::LEN_W-1:0]   year_days;

  logic [26:0]                 div_prod;
  logic [14:0]                 rem_diff;
  logic [gda_pkg::ORD_W-1:0]   alu_a, alu_b, alu_out;
  logic                        alu_sub;
  logic [gda_pkg::ORD_W-1:0]   cmp_len;
  logic                        gt;
  logic                        invalid;

  assign cal_month = (state == gda_pkg::ST_CHECK) ? mon : cnt;

  gda_calendar u_calendar (
    .yr_lo      (yr_lo),
    .yr_hi      (yr_hi),
    .month      (cal_month),
    .month_days (month_days),
    .year_days  (year_days)
  );

  assign div_prod = year * gda_pkg::RECIP_100;
  assign rem_diff = {1'b0, year} - (quo * gda_pkg::HUNDRED);

  always_comb begin
    alu_a   = ord;
    alu_b   = {{(gda_pkg::ORD_W-gda_pkg::DAY_W){1'b0}}, month_days};
    alu_sub = 1'b1;
    case (state)
      gda_pkg::ST_CHECK: begin
        alu_a   = {{(gda_pkg::ORD_W-gda_pkg::DAY_W){1'b0}}, day};
        alu_b   = {{(gda_pkg::ORD_W-gda_pkg::ADD_W){1'b0}}, add};
        alu_sub = 1'b0;
      end
      gda_pkg::ST_SUM: begin
        alu_sub = 1'b0;
      end
      gda_pkg::ST_YEAR: begin
        alu_b = {{(gda_pkg::ORD_W-gda_pkg::LEN_W){1'b0}}, year_days};
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
    alu_out = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  assign cmp_len = (state == gda_pkg::ST_YEAR)
                 ? {{(gda_pkg::ORD_W-gda_pkg::LEN_W){1'b0}}, year_days}
                 : {{(gda_pkg::ORD_W-gda_pkg::DAY_W){1'b0}}, month_days};
  assign gt = (ord > cmp_len);

  assign invalid = (year == '0) || (year > gda_pkg::YEAR_LIMIT) || (mon == '0) ||
                   (mon > gda_pkg::MONTH_LAST) || (day == '0) || (day > month_days);

  always_comb begin
    state_next = state;
    case (state)
      gda_pkg::ST_IDLE: begin
        if (start) begin
          state_next = gda_pkg::ST_DIV;
        end
      end
      gda_pkg::ST_DIV: begin
        state_next = gda_pkg::ST_REM;
      end
      gda_pkg::ST_REM: begin
        state_next = gda_pkg::ST_CHECK;
      end
      gda_pkg::ST_CHECK: begin
        if (invalid) begin
          state_next = gda_pkg::ST_IDLE;
        end else if (mon == gda_pkg::MONTH_FIRST) begin
          state_next = gda_pkg::ST_YEAR;
        end else begin
          state_next = gda_pkg::ST_SUM;
        end
      end
      gda_pkg::ST_SUM: begin
        if (cnt + gda_pkg::MONTH_FIRST == mon) begin
          state_next = gda_pkg::ST_YEAR;
        end
      end
      gda_pkg::ST_YEAR: begin
        if (gt) begin
          if (year == gda_pkg::YEAR_LIMIT) begin
            state_next = gda_pkg::ST_IDLE;
          end
        end else begin
          state_next = gda_pkg::ST_MONTH;
        end
      end
      gda_pkg::ST_MONTH: begin
        if (!(cnt < gda_pkg::MONTH_LAST && gt)) begin
          state_next = gda_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gda_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    year_next  = year;
    mon_next   = mon;
    day_next   = day;
    add_next   = add;
    quo_next   = quo;
    yr_lo_next = yr_lo;
    yr_hi_next = yr_hi;
    ord_next   = ord;
    cnt_next   = cnt;
    res_next   = res;
    done_next  = 1'b0;
    case (state)
      gda_pkg::ST_IDLE: begin
        if (start) begin
          year_next = request.start_year;
          mon_next  = request.start_month;
          day_next  = request.start_day;
          add_next  = request.days_to_add;
        end
      end
      gda_pkg::ST_DIV: begin
        quo_next = div_prod[26:gda_pkg::RECIP_SHIFT];
      end
      gda_pkg::ST_REM: begin
        yr_lo_next = rem_diff[gda_pkg::CENT_W-1:0];
        yr_hi_next = quo[gda_pkg::CENT_W-1:0];
      end
      gda_pkg::ST_CHECK: begin
        if (invalid) begin
          res_next  = '{end_year: '0, end_month: '0, end_day: '0, error: 1'b1};
          done_next = 1'b1;
        end else begin
          ord_next = alu_out;
          cnt_next = gda_pkg::MONTH_FIRST;
        end
      end
      gda_pkg::ST_SUM: begin
        ord_next = alu_out;
        cnt_next = cnt + gda_pkg::MONTH_FIRST;
      end
      gda_pkg::ST_YEAR: begin
        if (gt) begin
          if (year == gda_pkg::YEAR_LIMIT) begin
            res_next  = '{end_year: '0, end_month: '0, end_day: '0, error: 1'b1};
            done_next = 1'b1;
          end else begin
            ord_next  = alu_out;
            year_next = year + gda_pkg::YEAR_W'(1);
            if (yr_lo == gda_pkg::CENT_TOP) begin
              yr_lo_next = '0;
              yr_hi_next = yr_hi + gda_pkg::CENT_W'(1);
            end else begin
              yr_lo_next = yr_lo + gda_pkg::CENT_W'(1);
            end
          end
        end else begin
          cnt_next = gda_pkg::MONTH_FIRST;
        end
      end
      gda_pkg::ST_MONTH: begin
        if (cnt < gda_pkg::MONTH_LAST && gt) begin
          ord_next = alu_out;
          cnt_next = cnt + gda_pkg::MONTH_FIRST;
        end else begin
          res_next  = '{end_year: year, end_month: cnt, end_day: ord[gda_pkg::DAY_W-1:0],
                        error: 1'b0};
          done_next = 1'b1;
        end
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= gda_pkg::ST_IDLE;
      done_r <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= done_next;
    end
    year  <= year_next;
    mon   <= mon_next;
    day   <= day_next;
    add   <= add_next;
    quo   <= quo_next;
    yr_lo <= yr_lo_next;
    yr_hi <= yr_hi_next;
    ord   <= ord_next;
    cnt   <= cnt_next;
    res   <= res_next;
  end

  assign busy   = (state != gda_pkg::ST_IDLE);
  assign done   = done_r;
  assign result = res;

endmodule
